### hdl/query_text_tokenizer_unit_macros.svh
// Assertion macros for the query text tokenizer.
// Depends on nothing; the including module must have clk_i and rst_ni.
`ifndef QUERY_TEXT_TOKENIZER_UNIT_MACROS_SVH
`define QUERY_TEXT_TOKENIZER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define QTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition must never be seen outside reset.
`define QTT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define QTT_ASSERT(lbl, prop, msg)
`define QTT_NEVER(lbl, cond, msg)
`endif
`endif

### hdl/qtt_pkg.sv
// Types, character codes and classification functions for the query text
// tokenizer. Depends on nothing.
package qtt_pkg;

  localparam int unsigned MaxToken  = 64;
  localparam int unsigned LenW      = 6;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_WORD = 3'd1,
    MODE_STR  = 3'd2,
    MODE_QEND = 3'd3,
    MODE_OP   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_WORD = 2'd0,
    KIND_STR  = 2'd1,
    KIND_OP   = 2'd2,
    KIND_END  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] tbyte;
    logic       bvalid;
    kind_e      kind;
    logic       last;
    logic       trunc;
  } item_t;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChQmark  = 8'h3F;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChBar    = 8'h7C;

  function automatic logic is_word_char(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h30 && b <= 8'h39) || b == ChQmark || b == ChUscore ||
           b == ChDollar;
  endfunction

  function automatic logic is_op_start(input logic [7:0] b);
    return b == ChLt || b == ChGt || b == ChEq || b == ChAmp || b == ChBar;
  endfunction

  function automatic logic pairs_up(input logic [7:0] first, input logic [7:0] second);
    logic r;
    r = 1'b0;
    if (second == ChEq) r = (first == ChLt) || (first == ChGt) || (first == ChEq);
    else if (second == ChAmp) r = (first == ChAmp);
    else if (second == ChBar) r = (first == ChBar);
    return r;
  endfunction

  function automatic item_t mk_item(input logic [7:0] b, input logic v, input kind_e k,
                                    input logic l, input logic t);
    item_t it;
    it.tbyte  = b;
    it.bvalid = v;
    it.kind   = k;
    it.last   = l;
    it.trunc  = t;
    return it;
  endfunction

endpackage

### hdl/query_text_tokenizer_unit.sv
// Query text tokenizer: lexes one text byte per cycle into token items, while the result queue has room.
// A byte's items are registered into the result queue when the byte is transferred.
// Throughput: one byte per cycle; a byte can make up to two items, which
// drain through a four-entry result queue at one item per cycle while out_ready_i is high,
// and input is held off while fewer than two queue slots are free.
// Reset (rst_ni low, asynchronous): lexer idle, queue empty, limit 63.
`include "query_text_tokenizer_unit_macros.svh"
module query_text_tokenizer_unit
  import qtt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] token_byte_o,
  output logic       byte_valid_o,
  output logic [1:0] token_kind_o,
  output logic       token_last_o,
  output logic       truncated_o
);

  logic [5:0]      limit_q;
  mode_e           mode_q, mode_d;
  logic            qdbl_q, qdbl_d;
  logic [7:0]      pend_q, pend_d;
  logic [LenW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;

  logic [LenW-1:0] lim_eff;
  logic [7:0]      b;
  logic [7:0]      quote_ch;
  logic            in_fire, out_fire, idle_go;
  logic [1:0]      n_items;
  item_t           it [2];

  item_t           fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (count_q <= (PtrW+1)'(FifoDepth - 2));
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;

  // A limit of zero keeps one byte; the upper clamp is MaxToken - 1 (63).
  always_comb begin
    lim_eff = limit_q;
    if (limit_q == '0) lim_eff = LenW'(1);
    if (32'(lim_eff) > MaxToken - 1) lim_eff = LenW'(MaxToken - 1);
  end

  assign b        = text_byte_i;
  assign quote_ch = qdbl_q ? ChDquote : ChSquote;

  always_comb begin
    mode_d  = mode_q;
    qdbl_d  = qdbl_q;
    pend_d  = pend_q;
    len_d   = len_q;
    ovf_d   = ovf_q;
    n_items = '0;
    idle_go = 1'b0;
    it[0]   = mk_item(8'h00, 1'b0, KIND_WORD, 1'b0, 1'b0);
    it[1]   = it[0];

    case (mode_q)
      MODE_WORD: begin
        if (is_word_char(b)) begin
          if (len_q < lim_eff) begin
            len_d   = len_q + LenW'(1);
            it[0]   = mk_item(b, 1'b1, KIND_WORD, 1'b0, 1'b0);
            n_items = 2'd1;
          end else begin
            ovf_d = 1'b1;
          end
        end else begin
          it[0]   = mk_item(8'h00, 1'b0, KIND_WORD, 1'b1, ovf_q);
          n_items = 2'd1;
          idle_go = 1'b1;
        end
      end
      MODE_STR: begin
        if (b == quote_ch) begin
          mode_d = MODE_QEND;
        end else if (b == ChNul) begin
          it[0]   = mk_item(8'h00, 1'b0, KIND_STR, 1'b1, ovf_q);
          n_items = 2'd1;
          idle_go = 1'b1;
        end else if (len_q < lim_eff) begin
          len_d   = len_q + LenW'(1);
          it[0]   = mk_item(b, 1'b1, KIND_STR, 1'b0, 1'b0);
          n_items = 2'd1;
        end else begin
          ovf_d = 1'b1;
        end
      end
      MODE_QEND: begin
        if (b == quote_ch) begin
          // A doubled quote stands for one quote byte inside the string.
          mode_d = MODE_STR;
          if (len_q < lim_eff) begin
            len_d   = len_q + LenW'(1);
            it[0]   = mk_item(b, 1'b1, KIND_STR, 1'b0, 1'b0);
            n_items = 2'd1;
          end else begin
            ovf_d = 1'b1;
          end
        end else begin
          it[0]   = mk_item(8'h00, 1'b0, KIND_STR, 1'b1, ovf_q);
          n_items = 2'd1;
          idle_go = 1'b1;
        end
      end
      MODE_OP: begin
        mode_d = MODE_IDLE;
        pend_d = 8'h00;
        if (pairs_up(pend_q, b)) begin
          if (lim_eff >= LenW'(2)) begin
            it[0]   = mk_item(pend_q, 1'b1, KIND_OP, 1'b0, 1'b0);
            it[1]   = mk_item(b, 1'b1, KIND_OP, 1'b1, 1'b0);
            n_items = 2'd2;
          end else begin
            it[0]   = mk_item(pend_q, 1'b1, KIND_OP, 1'b1, 1'b1);
            n_items = 2'd1;
          end
        end else begin
          it[0]   = mk_item(pend_q, 1'b1, KIND_OP, 1'b1, 1'b0);
          n_items = 2'd1;
          idle_go = 1'b1;
        end
      end
      default: idle_go = 1'b1;
    endcase

    // The byte is lexed afresh, after any item that closed the previous token.
    if (idle_go) begin
      mode_d = MODE_IDLE;
      len_d  = '0;
      ovf_d  = 1'b0;
      if (b == ChNul || b == ChSemi) begin
        it[n_items[0]] = mk_item(8'h00, 1'b0, KIND_END, 1'b1, 1'b0);
        n_items        = n_items + 2'd1;
      end else if (b <= ChSpace || b[7]) begin
        mode_d = MODE_IDLE;
      end else if (b == ChDquote || b == ChSquote) begin
        mode_d = MODE_STR;
        qdbl_d = (b == ChDquote);
      end else if (is_word_char(b)) begin
        mode_d         = MODE_WORD;
        len_d          = LenW'(1);
        it[n_items[0]] = mk_item(b, 1'b1, KIND_WORD, 1'b0, 1'b0);
        n_items        = n_items + 2'd1;
      end else if (is_op_start(b)) begin
        mode_d = MODE_OP;
        pend_d = b;
      end else begin
        it[n_items[0]] = mk_item(b, 1'b1, KIND_OP, 1'b1, 1'b0);
        n_items        = n_items + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 6'd63;
      mode_q  <= MODE_IDLE;
      qdbl_q  <= 1'b0;
      pend_q  <= 8'h00;
      len_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) limit_q <= cfg_data_i;
      if (in_fire) begin
        mode_q <= mode_d;
        qdbl_q <= qdbl_d;
        pend_q <= pend_d;
        len_q  <= len_d;
        ovf_q  <= ovf_d;
      end
    end
  end

  // Result queue: up to two entries written per transfer, one read per cycle while out_ready_i is high.
  logic [1:0] push_n;
  assign push_n = in_fire ? n_items : 2'd0;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) fifo_q[wr_ptr_q] <= it[0];
    if (push_n == 2'd2) fifo_q[wr_ptr_q + PtrW'(1)] <= it[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      if (out_fire) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      count_q <= count_q + (PtrW+1)'(push_n) - (PtrW+1)'(out_fire);
    end
  end

  item_t head;
  assign head         = fifo_q[rd_ptr_q];
  assign token_byte_o = head.tbyte;
  assign byte_valid_o = head.bvalid;
  assign token_kind_o = head.kind;
  assign token_last_o = head.last;
  assign truncated_o  = head.trunc;

  `QTT_NEVER(a_fifo_bound, count_q > (PtrW+1)'(FifoDepth), "result queue overfilled")
  `QTT_ASSERT(a_op_emits, (in_fire && mode_q == MODE_OP) |=> (count_q != '0), "operator lost")
  `QTT_ASSERT(a_idle_clear, (mode_q == MODE_IDLE) |-> (len_q == '0 && !ovf_q), "stale length")

endmodule
